// File: rtl/hbr_pkg.sv
// hbr_pkg: shared types, codes and constants for the h-bridge speed ramp drive
// used by hbr_ctrl, hbr_scale and hbridge_speed_ramp_drive; no dependencies
package hbr_pkg;

   // command kinds carried in req_tuser
   typedef enum logic [2:0] {
      MODE_SET    = 3'd0,
      MODE_TICK   = 3'd1,
      MODE_BRAKE  = 3'd2,
      MODE_ENABLE = 3'd3,
      MODE_READ   = 3'd4
   } mode_type;

   // register indexes on the csr port
   localparam logic [1:0] CSR_RAMP_STEP  = 2'd0;
   localparam logic [1:0] CSR_DEAD_BAND  = 2'd1;
   localparam logic [1:0] CSR_FULL_SCALE = 2'd2;

   localparam logic [6:0]  RAMP_STEP_RST  = 7'd2;
   localparam logic [6:0]  DEAD_BAND_RST  = 7'd10;
   localparam logic [12:0] FULL_SCALE_RST = 13'd4096;

   localparam logic [7:0] SPEED_MAX  = 8'd200;
   localparam logic [7:0] SPEED_STOP = 8'd100;
   localparam logic [6:0] PCT_FULL   = 7'd100;

   // floor(x / 100) = (x * ceil(2^26 / 100)) >> 26, exact for x below 1.8e6
   localparam logic [19:0] DIV100_RECIP = 20'd671089;
   localparam int          DIV100_SHIFT = 26;

   typedef struct packed {
      logic [6:0]  ramp_step;
      logic [6:0]  dead_band;
      logic [12:0] full_scale;
   } cfg_type;

   typedef struct packed {
      logic [2:0] mode;
      logic [7:0] speed_cmd;
      logic [7:0] brake_cmd;
      logic       enable_level;
   } item_type;

   // result of the state step, carried to the duty scaling stage
   typedef struct packed {
      logic [19:0] product;
      logic        load_duty;
      logic        bridge_a;
      logic        bridge_b;
      logic        fault_seen;
   } step_type;

endpackage

// File: rtl/hbr_ctrl.sv
// hbr_ctrl: speed, direction and fault state, stepped once per word
// depends on hbr_pkg
module hbr_ctrl
   import hbr_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     fire,
   input  item_type item,
   input  cfg_type  cfg,
   output step_type step
);

   logic [7:0] present_ff, present_in;
   logic [7:0] target_ff, target_in;
   logic       fault_ff, fault_in;
   logic       rsc_ff, rsc_in;
   logic       line_a_ff, line_a_in;
   logic       line_b_ff, line_b_in;

   logic [6:0] mag;
   logic       neg;
   logic [6:0] brake_pct;
   logic [6:0] pct;
   logic [8:0] ramp_sum;
   mode_type   mode;

   assign mode = mode_type'(item.mode);

   always_comb begin
      if (present_ff >= SPEED_STOP) begin
         mag = 7'(present_ff - SPEED_STOP);
      end else begin
         mag = 7'(SPEED_STOP - present_ff);
      end
      // a stopped motor counts as reverse
      neg       = (present_ff <= SPEED_STOP);
      brake_pct = (item.brake_cmd > 8'(PCT_FULL)) ? PCT_FULL : item.brake_cmd[6:0];
      ramp_sum  = {1'b0, present_ff} + {2'b00, cfg.ramp_step};
   end

   always_comb begin
      present_in      = present_ff;
      target_in       = target_ff;
      fault_in        = fault_ff;
      rsc_in          = rsc_ff;
      line_a_in       = line_a_ff;
      line_b_in       = line_b_ff;
      pct             = brake_pct;
      step.load_duty  = 1'b0;
      step.fault_seen = 1'b0;
      unique case (mode)
         MODE_SET: begin
            target_in = (item.speed_cmd > SPEED_MAX) ? SPEED_MAX : item.speed_cmd;
         end
         MODE_TICK: begin
            pct            = mag;
            step.load_duty = 1'b1;
            if (mag < cfg.dead_band) begin
               line_a_in = 1'b0;
               line_b_in = 1'b0;
            end else if (neg) begin
               line_a_in = 1'b0;
               line_b_in = 1'b1;
            end else begin
               line_a_in = 1'b1;
               line_b_in = 1'b0;
            end
            // ramp toward target, may overshoot it, saturates at the ends
            if (target_ff > present_ff) begin
               present_in = (ramp_sum > {1'b0, SPEED_MAX}) ? SPEED_MAX : ramp_sum[7:0];
            end else if (target_ff < present_ff) begin
               present_in = (present_ff < {1'b0, cfg.ramp_step}) ? 8'd0 :
                            8'(present_ff - {1'b0, cfg.ramp_step});
            end
         end
         MODE_BRAKE: begin
            step.load_duty = 1'b1;
            line_a_in      = 1'b0;
            line_b_in      = 1'b0;
         end
         MODE_ENABLE: begin
            fault_in = !(item.enable_level && rsc_ff);
            rsc_in   = 1'b0;
         end
         MODE_READ: begin
            step.fault_seen = fault_ff;
            fault_in        = !item.enable_level;
            rsc_in          = 1'b1;
         end
         default: begin
         end
      endcase
      step.product  = 20'(cfg.full_scale) * 20'(pct);
      step.bridge_a = line_a_in;
      step.bridge_b = line_b_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff <= SPEED_STOP;
         target_ff  <= SPEED_STOP;
         fault_ff   <= 1'b0;
         rsc_ff     <= 1'b0;
         line_a_ff  <= 1'b0;
         line_b_ff  <= 1'b0;
      end else if (fire) begin
         present_ff <= present_in;
         target_ff  <= target_in;
         fault_ff   <= fault_in;
         rsc_ff     <= rsc_in;
         line_a_ff  <= line_a_in;
         line_b_ff  <= line_b_in;
      end
   end

   a_present_range: assert property (@(posedge clock) disable iff (reset)
      present_ff <= SPEED_MAX)
      else $error("present speed beyond full scale");

   a_target_range: assert property (@(posedge clock) disable iff (reset)
      target_ff <= SPEED_MAX)
      else $error("target speed beyond full scale");

   a_lines_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(line_a_ff && line_b_ff))
      else $error("both bridge lines driven high");

   a_seen_on_read: assert property (@(posedge clock) disable iff (reset)
      (fire && step.fault_seen) |-> (item.mode == MODE_READ) && fault_ff)
      else $error("fault_seen raised outside a fault read");

endmodule

// File: rtl/hbr_scale.sv
// hbr_scale: divides the duty product by one hundred and holds the driven duty
// depends on hbr_pkg
module hbr_scale
   import hbr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        fire,
   input  step_type    step,
   output logic [12:0] duty
);

   logic [12:0] duty_ff, duty_in;
   logic [39:0] recip_prod;

   assign recip_prod = 40'(step.product) * 40'(DIV100_RECIP);
   assign duty_in    = step.load_duty ? recip_prod[DIV100_SHIFT +: 13] : duty_ff;
   assign duty       = duty_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         duty_ff <= 13'd0;
      end else if (fire) begin
         duty_ff <= duty_in;
      end
   end

endmodule

// File: rtl/hbridge_speed_ramp_drive.sv
// hbridge_speed_ramp_drive: top level of the slew-limited h-bridge pwm drive
// depends on hbr_pkg, hbr_ctrl, hbr_scale
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+------------------------------------------
//  req     | in  | req_tvalid/tready   | tuser mode, tdata speed/brake/enable
//  rsp     | out | rsp_tvalid/tready   | tdata duty, bridge a/b, fault_seen
//  csr     | in  | csr_we              | csr_index, csr_wdata, no back-pressure
//
// one word accepted per cycle while rsp is not stalled; each word's result reaches rsp through
// the input, step and output registers (state step and duty product, then divide by one hundred)
// the state step is registered as the word leaves the input register, so the next word sees it at once
// each register stage moves on when the one after it is empty or moving
// synchronous active-high reset: speeds to stop, fault clear, duty and lines low
module hbridge_speed_ramp_drive
   import hbr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // speed_cmd[7:0], brake_cmd[15:8], enable_level[16], zero
   input  logic [2:0]  req_tuser,  // mode[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // pwm_duty[12:0], bridge_a[13], bridge_b[14], fault_seen[15]
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_wdata
);

   cfg_type     cfg_ff;

   logic        in_v_ff, in_v_in;
   item_type    in_item_ff;
   logic        mid_v_ff, mid_v_in;
   step_type    mid_ff;
   step_type    step;
   logic        out_v_ff, out_v_in;
   logic [15:0] out_data_ff;
   logic [12:0] duty;

   logic        adv_out, adv_mid, adv_in;
   logic        fire_mid, fire_out, accept;

   // stage advance chain, back from the result side
   assign adv_out  = !out_v_ff || rsp_tready;
   assign adv_mid  = !mid_v_ff || adv_out;
   assign adv_in   = !in_v_ff || adv_mid;
   assign fire_mid = in_v_ff && adv_mid;
   assign fire_out = mid_v_ff && adv_out;
   assign accept   = req_tvalid && adv_in;

   assign req_tready = adv_in;
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_data_ff;

   assign in_v_in  = accept ? 1'b1 : (fire_mid ? 1'b0 : in_v_ff);
   assign mid_v_in = fire_mid ? 1'b1 : (fire_out ? 1'b0 : mid_v_ff);
   assign out_v_in = fire_out ? 1'b1 : ((out_v_ff && rsp_tready) ? 1'b0 : out_v_ff);

   // configuration registers, out-of-range index ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ramp_step  <= RAMP_STEP_RST;
         cfg_ff.dead_band  <= DEAD_BAND_RST;
         cfg_ff.full_scale <= FULL_SCALE_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_RAMP_STEP:  cfg_ff.ramp_step  <= csr_wdata[6:0];
            CSR_DEAD_BAND:  cfg_ff.dead_band  <= csr_wdata[6:0];
            CSR_FULL_SCALE: cfg_ff.full_scale <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff  <= 1'b0;
         mid_v_ff <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         in_v_ff  <= in_v_in;
         mid_v_ff <= mid_v_in;
         out_v_ff <= out_v_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         in_item_ff.mode         <= req_tuser;
         in_item_ff.speed_cmd    <= req_tdata[7:0];
         in_item_ff.brake_cmd    <= req_tdata[15:8];
         in_item_ff.enable_level <= req_tdata[16];
      end
      if (fire_mid) begin
         mid_ff <= step;
      end
      if (fire_out) begin
         out_data_ff <= {mid_ff.fault_seen, mid_ff.bridge_b, mid_ff.bridge_a, duty};
      end
   end

   // speed ramp, direction and fault state; product of full scale and percent
   hbr_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .fire  (fire_mid),
      .item  (in_item_ff),
      .cfg   (cfg_ff),
      .step  (step)
   );

   // divide by one hundred and hold the driven duty
   hbr_scale u_scale (
      .clock (clock),
      .reset (reset),
      .fire  (fire_out),
      .step  (mid_ff),
      .duty  (duty)
   );

endmodule
